@@ src/rgb_pooling_downsampler_top_defines.svh @@
// Assertion macros used by the pooling downsampler RTL.
`ifndef RGB_POOLING_DOWNSAMPLER_TOP_DEFINES_SVH
`define RGB_POOLING_DOWNSAMPLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RGBPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rgbpd: property failed");
`define RGBPD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rgbpd: forbidden condition seen");
`else
`define RGBPD_ASSERT(lbl, clk, rst_n, prop)
`define RGBPD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ src/rgbpd_pkg.sv @@
// Types, constants and the reciprocal table of the pooling downsampler.
package rgbpd_pkg;

  localparam int unsigned CHANNELS      = 3;
  localparam int unsigned PIX_BITS      = 8;
  localparam int unsigned PART_BITS     = 14;
  localparam int unsigned ENTRY_BITS    = CHANNELS * PART_BITS;
  localparam int unsigned CFG_DATA_BITS = 13;
  localparam int unsigned WCFG_BITS     = 11;
  localparam int unsigned HCFG_BITS     = 13;
  localparam int unsigned KCFG_BITS     = 4;
  localparam int unsigned KSEL_BITS     = 5;
  // q = (acc * RECIP) >> RECIP_SHIFT is exact for acc < 2^14 and k*k <= 256
  localparam int unsigned RECIP_SHIFT   = 22;
  localparam int unsigned RECIP_BITS    = 23;
  localparam int unsigned PROD_BITS     = PART_BITS + RECIP_BITS;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_POOL_SIZE    = 2'd2,
    CFG_POOL_MODE    = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    MODE_MAX = 1'b0,
    MODE_AVG = 1'b1
  } pool_mode_e;

  typedef struct packed {
    logic                frame_start;
    logic [PIX_BITS-1:0] red;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] out_red;
    logic [PIX_BITS-1:0] out_green;
    logic [PIX_BITS-1:0] out_blue;
    logic                frame_last;
  } pix_out_t;

  // ceil(2^22 / (k*k)) for window side k
  function automatic logic [RECIP_BITS-1:0] recip(input logic [KSEL_BITS-1:0] k);
    logic [RECIP_BITS-1:0] r;
    unique case (k)
      5'd2:    r = 23'd1048576;
      5'd3:    r = 23'd466034;
      5'd4:    r = 23'd262144;
      5'd5:    r = 23'd167773;
      5'd6:    r = 23'd116509;
      5'd7:    r = 23'd85599;
      5'd8:    r = 23'd65536;
      5'd9:    r = 23'd51782;
      5'd10:   r = 23'd41944;
      5'd11:   r = 23'd34664;
      5'd12:   r = 23'd29128;
      5'd13:   r = 23'd24819;
      5'd14:   r = 23'd21400;
      5'd15:   r = 23'd18642;
      5'd16:   r = 23'd16384;
      default: r = 23'd4194304;
    endcase
    return r;
  endfunction

endpackage

@@ src/rgbpd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rgbpd_ram #(
  parameter int unsigned WIDTH = 42,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/rgb_pooling_downsampler_top.sv @@
// Top level of the RGB max / average pooling downsampler.
// Takes one pixel per clock in raster order while in_stall_o is low and emits one pooled
// pixel per k-by-k window. out_valid_o is driven from the output register, fed through
// stage 1 and stage 2 from the edge that takes the window's bottom-right pixel. The rate is
// one pixel per cycle while in_stall_o is low, set by the line store's read-modify-write;
// back-to-back hits on the same window column are forwarded from the write stage. After
// reset and after every register write the block holds in_stall_o high while a bit-serial
// divider derives the largest whole-window span of the image. The line store is never
// cleared: the first pixel of each window overwrites its entry.
`include "rgb_pooling_downsampler_top_defines.svh"

module rgb_pooling_downsampler_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_POOL   = 8,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  rgbpd_pkg::pix_in_t                       in_data_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output rgbpd_pkg::pix_out_t                      out_data_o,
  input  logic                                     cfg_we_i,
  input  rgbpd_pkg::cfg_idx_e                      cfg_index_i,
  input  logic [rgbpd_pkg::CFG_DATA_BITS-1:0]      cfg_wdata_i
);
  import rgbpd_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW  = $clog2(MAX_POOL + 1);
  localparam int unsigned DW  = (WW > HW) ? WW : HW;
  localparam int unsigned DCW = $clog2(DW);

  // ---------------- configuration registers ----------------
  logic [WCFG_BITS-1:0] image_width_q;
  logic [HCFG_BITS-1:0] image_height_q;
  logic [KCFG_BITS-1:0] pool_size_q;
  pool_mode_e           pool_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WCFG_BITS'(480);
      image_height_q <= HCFG_BITS'(480);
      pool_size_q    <= KCFG_BITS'(2);
      pool_mode_q    <= MODE_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata_i[WCFG_BITS-1:0];
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_wdata_i[HCFG_BITS-1:0];
        CFG_POOL_SIZE:    pool_size_q    <= cfg_wdata_i[KCFG_BITS-1:0];
        CFG_POOL_MODE:    pool_mode_q    <= pool_mode_e'(cfg_wdata_i[0]);
        default:          ;
      endcase
    end
  end

  // Saturated working values.
  logic [WW-1:0] w_sat;
  logic [HW-1:0] h_sat;
  logic [PW-1:0] k_sat;
  logic [CW-1:0] w_m1;
  logic [RW-1:0] h_m1;
  logic [PW-1:0] k_m1;

  always_comb begin
    if (image_width_q == '0) begin
      w_sat = WW'(1);
    end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(image_width_q);
    end
    if (image_height_q == '0) begin
      h_sat = HW'(1);
    end else if (32'(image_height_q) > 32'(MAX_HEIGHT)) begin
      h_sat = HW'(MAX_HEIGHT);
    end else begin
      h_sat = HW'(image_height_q);
    end
    if (pool_size_q == '0) begin
      k_sat = PW'(1);
    end else if (32'(pool_size_q) > 32'(MAX_POOL)) begin
      k_sat = PW'(MAX_POOL);
    end else begin
      k_sat = PW'(pool_size_q);
    end
    w_m1 = CW'(w_sat - WW'(1));
    h_m1 = RW'(h_sat - HW'(1));
    k_m1 = k_sat - PW'(1);
  end

  // ---------------- span derivation: w - (w mod k), h - (h mod k) ----------------
  logic           div_start_q, div_busy_q;
  logic [DCW-1:0] div_cnt_q;
  logic [DW-1:0]  div_w_q, div_h_q;
  logic [PW-1:0]  rem_w_q, rem_h_q, rem_w_d, rem_h_d;
  logic [PW:0]    shl_w, shl_h;
  logic [WW-1:0]  span_w_q;
  logic [HW-1:0]  span_h_q;
  logic           div_done;

  always_comb begin
    shl_w = {rem_w_q, div_w_q[DW-1]};
    shl_h = {rem_h_q, div_h_q[DW-1]};
    rem_w_d = (shl_w >= {1'b0, k_sat}) ? PW'(shl_w - {1'b0, k_sat}) : PW'(shl_w);
    rem_h_d = (shl_h >= {1'b0, k_sat}) ? PW'(shl_h - {1'b0, k_sat}) : PW'(shl_h);
    div_done = div_busy_q && !div_start_q && (div_cnt_q == DCW'(DW - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_start_q <= 1'b1;
      div_busy_q  <= 1'b0;
      div_cnt_q   <= '0;
    end else if (cfg_we_i) begin
      div_start_q <= 1'b1;
    end else if (div_start_q) begin
      div_start_q <= 1'b0;
      div_busy_q  <= 1'b1;
      div_cnt_q   <= '0;
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q + DCW'(1);
      if (div_done) begin
        div_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start_q) begin
      div_w_q <= DW'(w_sat);
      div_h_q <= DW'(h_sat);
      rem_w_q <= '0;
      rem_h_q <= '0;
    end else if (div_busy_q) begin
      div_w_q <= div_w_q << 1;
      div_h_q <= div_h_q << 1;
      rem_w_q <= rem_w_d;
      rem_h_q <= rem_h_d;
      if (div_done) begin
        span_w_q <= w_sat - WW'(rem_w_d);
        span_h_q <= h_sat - HW'(rem_h_d);
      end
    end
  end

  // ---------------- handshake ----------------
  logic out_valid_q;
  logic advance;
  logic accept;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance || div_start_q || div_busy_q;
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------- position counters ----------------
  logic [CW-1:0] in_column_q, out_column_q, col0, col_d, ocol0, ocol_d;
  logic [RW-1:0] in_row_q, row0, row_d;
  logic [PW-1:0] column_phase_q, row_phase_q, cph0, rph0, cph_d, rph_d;
  logic          in_span, win_first, win_last, frame_last;

  always_comb begin
    col0  = in_data_i.frame_start ? '0 : in_column_q;
    row0  = in_data_i.frame_start ? '0 : in_row_q;
    cph0  = in_data_i.frame_start ? '0 : column_phase_q;
    rph0  = in_data_i.frame_start ? '0 : row_phase_q;
    ocol0 = in_data_i.frame_start ? '0 : out_column_q;

    in_span    = (WW'(col0) < span_w_q) && (HW'(row0) < span_h_q);
    win_first  = (cph0 == '0) && (rph0 == '0);
    win_last   = (cph0 >= k_m1) && (rph0 >= k_m1);
    frame_last = ((WW'(col0) + WW'(1)) == span_w_q) && ((HW'(row0) + HW'(1)) == span_h_q);

    col_d  = col0 + CW'(1);
    row_d  = row0;
    cph_d  = cph0 + PW'(1);
    rph_d  = rph0;
    ocol_d = ocol0;
    if (col0 >= w_m1) begin
      col_d  = '0;
      cph_d  = '0;
      ocol_d = '0;
      if (row0 >= h_m1) begin
        row_d = '0;
        rph_d = '0;
      end else begin
        row_d = row0 + RW'(1);
        rph_d = (rph0 >= k_m1) ? '0 : rph0 + PW'(1);
      end
    end else if (cph0 >= k_m1) begin
      cph_d  = '0;
      ocol_d = ocol0 + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_column_q    <= '0;
      in_row_q       <= '0;
      column_phase_q <= '0;
      row_phase_q    <= '0;
      out_column_q   <= '0;
    end else if (accept) begin
      in_column_q    <= col_d;
      in_row_q       <= row_d;
      column_phase_q <= cph_d;
      row_phase_q    <= rph_d;
      out_column_q   <= ocol_d;
    end
  end

  // ---------------- line store ----------------
  logic                                 ram_we, ram_re;
  logic [CW-1:0]                        ram_waddr;
  logic [CHANNELS-1:0][PART_BITS-1:0]   ram_rdata, old_part, fresh_part;

  // ---------------- stage 1: read-modify-write ----------------
  logic                               s1_valid_q;
  logic [CHANNELS-1:0][PIX_BITS-1:0]  s1_px_q;
  logic                               s1_first_q, s1_last_q, s1_flast_q, s1_fwd_q;
  pool_mode_e                         s1_mode_q;
  logic [PW-1:0]                      s1_k_q;
  logic [CW-1:0]                      s1_idx_q;
  logic [CHANNELS-1:0][PART_BITS-1:0] s1_fwd_data_q;

  always_comb begin
    old_part = s1_fwd_q ? s1_fwd_data_q : ram_rdata;
    for (int c = 0; c < CHANNELS; c++) begin
      if (s1_first_q) begin
        fresh_part[c] = PART_BITS'(s1_px_q[c]);
      end else if (s1_mode_q == MODE_AVG) begin
        fresh_part[c] = old_part[c] + PART_BITS'(s1_px_q[c]);
      end else begin
        fresh_part[c] = (old_part[c] > PART_BITS'(s1_px_q[c])) ?
                        old_part[c] : PART_BITS'(s1_px_q[c]);
      end
    end
  end

  assign ram_we    = s1_valid_q && advance;
  assign ram_waddr = s1_idx_q;
  assign ram_re    = accept && in_span;

  rgbpd_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (fresh_part),
    .re_i    (ram_re),
    .raddr_i (ocol0),
    .rdata_o (ram_rdata)
  );

  // ---------------- stage 2 and output ----------------
  logic                               s2_valid_q, s2_flast_q;
  pool_mode_e                         s2_mode_q;
  logic [RECIP_BITS-1:0]              s2_recip_q;
  logic [CHANNELS-1:0][PART_BITS-1:0] s2_acc_q;
  logic [CHANNELS-1:0][PIX_BITS-1:0]  pooled;
  logic [PROD_BITS-1:0]               prod [CHANNELS];
  pix_out_t                           out_data_q;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      prod[c] = PROD_BITS'(s2_acc_q[c]) * PROD_BITS'(s2_recip_q);
      pooled[c] = (s2_mode_q == MODE_AVG) ? prod[c][RECIP_SHIFT +: PIX_BITS]
                                          : s2_acc_q[c][PIX_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= accept && in_span;
      s2_valid_q  <= s1_valid_q && s1_last_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (accept) begin
        s1_px_q       <= {in_data_i.blue, in_data_i.green, in_data_i.red};
        s1_first_q    <= win_first;
        s1_last_q     <= win_last;
        s1_flast_q    <= frame_last;
        s1_mode_q     <= pool_mode_q;
        s1_k_q        <= k_sat;
        s1_idx_q      <= ocol0;
        // entry being written back this edge is not yet visible to the read
        s1_fwd_q      <= s1_valid_q && (s1_idx_q == ocol0);
        s1_fwd_data_q <= fresh_part;
      end
      s2_acc_q   <= fresh_part;
      s2_mode_q  <= s1_mode_q;
      s2_recip_q <= recip(KSEL_BITS'(s1_k_q));
      s2_flast_q <= s1_flast_q;
      out_data_q.out_red    <= pooled[0];
      out_data_q.out_green  <= pooled[1];
      out_data_q.out_blue   <= pooled[2];
      out_data_q.frame_last <= s2_flast_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------- checks ----------------
  `RGBPD_ASSERT(a_fwd_matches_write, clk_i, rst_ni,
    (s1_valid_q && s1_fwd_q && $past(accept)) |->
      ($past(ram_we) && ($past(ram_waddr) == s1_idx_q)))
  `RGBPD_ASSERT(a_span_within_image, clk_i, rst_ni,
    (!div_start_q && !div_busy_q) |-> ((span_w_q <= w_sat) && (span_h_q <= h_sat)))
  `RGBPD_ASSERT(a_rem_below_k, clk_i, rst_ni,
    (div_busy_q && !div_start_q) |-> ((rem_w_q < k_sat) && (rem_h_q < k_sat)))
  `RGBPD_ASSERT_NEVER(a_result_from_nowhere, clk_i, rst_ni,
    $rose(out_valid_q) && !$past(s2_valid_q))

endmodule

@@ test/tb_rgb_pooling_downsampler_top.sv @@
// Self-checking testbench for the RGB max/average pooling downsampler top level.
`timescale 1ns / 1ps

module tb_rgb_pooling_downsampler_top;
  import rgbpd_pkg::*;

  localparam int unsigned LINE_DEPTH   = 1024;
  localparam int unsigned POOL_MAX     = 8;
  localparam int unsigned ROWS_MAX     = 4096;
  localparam int unsigned DRAIN_CYCLES = 12;

  logic       clk = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  pix_in_t    in_pixel = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  pix_out_t   out_pixel;
  logic       cfg_we = 1'b0;
  cfg_idx_e   cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // predictor copy of configuration and position state
  logic [WCFG_BITS-1:0] cfg_width = 11'd480;
  logic [HCFG_BITS-1:0] cfg_height = 13'd480;
  logic [KCFG_BITS-1:0] cfg_pool = 4'd2;
  pool_mode_e           cfg_mode = MODE_MAX;
  int unsigned col_cnt = 0, row_cnt = 0, col_ph = 0, row_ph = 0, win_col = 0;
  logic [ENTRY_BITS-1:0] line_store [LINE_DEPTH];

  pix_out_t pooled_expect_q [$];
  int unsigned err_count = 0;

  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;
  int unsigned rx_hold_cycles = 0;

  rgb_pooling_downsampler_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_pixel),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_pixel),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always #2 clk = ~clk;

  initial begin
    for (int i = 0; i < LINE_DEPTH; i++) line_store[i] = '0;
  end

  function automatic int unsigned clamp_u(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Advance the pooling state by one accepted pixel; queue the pooled pixel it completes.
  function automatic void predict_pixel(input pix_in_t px);
    int unsigned w, h, k, span_w, span_h, idx, prev, acc, c;
    logic [7:0] smp [3];
    logic [7:0] pooled [3];
    logic [ENTRY_BITS-1:0] old_ent, new_ent;
    bit first_px, last_px;
    pix_out_t res;
    w = clamp_u(cfg_width, 1, LINE_DEPTH);
    h = clamp_u(cfg_height, 1, ROWS_MAX);
    k = clamp_u(cfg_pool, 1, POOL_MAX);
    span_w = (w / k) * k;
    span_h = (h / k) * k;
    smp[0] = px.red;
    smp[1] = px.green;
    smp[2] = px.blue;
    if (px.frame_start) begin
      col_cnt = 0; row_cnt = 0; col_ph = 0; row_ph = 0; win_col = 0;
    end
    if (col_cnt < span_w && row_cnt < span_h) begin
      idx = win_col % LINE_DEPTH;
      old_ent = line_store[idx];
      new_ent = '0;
      first_px = (col_ph == 0 && row_ph == 0);
      last_px = (col_ph >= k - 1 && row_ph >= k - 1);
      for (c = 0; c < CHANNELS; c++) begin
        prev = old_ent[c*PART_BITS +: PART_BITS];
        if (first_px) acc = smp[c];
        else if (cfg_mode == MODE_AVG) acc = (prev + smp[c]) & ((1 << PART_BITS) - 1);
        else acc = (prev > smp[c]) ? prev : smp[c];
        new_ent[c*PART_BITS +: PART_BITS] = acc[PART_BITS-1:0];
        pooled[c] = (cfg_mode == MODE_AVG) ? 8'(acc / (k * k)) : 8'(acc);
      end
      line_store[idx] = new_ent;
      if (last_px) begin
        res.out_red = pooled[0];
        res.out_green = pooled[1];
        res.out_blue = pooled[2];
        res.frame_last = (col_cnt == span_w - 1 && row_cnt == span_h - 1);
        pooled_expect_q.push_back(res);
      end
    end
    if (col_cnt >= w - 1) begin
      col_cnt = 0; col_ph = 0; win_col = 0;
      if (row_cnt >= h - 1) begin
        row_cnt = 0; row_ph = 0;
      end else begin
        row_cnt++;
        row_ph = (row_ph >= k - 1) ? 0 : row_ph + 1;
      end
    end else begin
      col_cnt++;
      if (col_ph >= k - 1) begin
        col_ph = 0;
        win_col++;
      end else begin
        col_ph++;
      end
    end
  endfunction

  // Offer one pixel request and wait for the block to take it.
  task automatic send_pixel(input logic fs, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    int unsigned gap;
    pix_in_t px;
    px.frame_start = fs;
    px.red = r;
    px.green = g;
    px.blue = b;
    gap = tx_idling ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (in_stall);
    predict_pixel(px);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pooled_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_we high; set_config lowers it after the last write
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH:  cfg_width = val[WCFG_BITS-1:0];
      CFG_IMAGE_HEIGHT: cfg_height = val[HCFG_BITS-1:0];
      CFG_POOL_SIZE:    cfg_pool = val[KCFG_BITS-1:0];
      CFG_POOL_MODE:    cfg_mode = pool_mode_e'(val[0]);
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_DATA_BITS-1:0] w, input logic [CFG_DATA_BITS-1:0] h,
                            input logic [CFG_DATA_BITS-1:0] k, input pool_mode_e mode);
    wait_for_drain();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_POOL_SIZE, k);
    write_reg(CFG_POOL_MODE, {{(CFG_DATA_BITS-1){1'b0}}, mode});
    cfg_we <= 1'b0;
  endtask

  // receiver: random stall stretches, or a long hold-off when one is requested
  initial begin
    int unsigned n;
    wait (rst_ni);
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_stall <= 1'b1;
      end else if (!rx_idling || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 12);
      end else begin
        out_stall <= 1'b1;
        n = pick_gap() + 1;
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    pix_out_t exp_px;
    if (rst_ni && out_valid && !out_stall) begin
      if (pooled_expect_q.size() == 0) begin
        if (err_count < 30)
          $display("%0t: unexpected pooled pixel r=%02h g=%02h b=%02h last=%0b", $time,
                   out_pixel.out_red, out_pixel.out_green, out_pixel.out_blue,
                   out_pixel.frame_last);
        err_count++;
      end else begin
        exp_px = pooled_expect_q.pop_front();
        if (out_pixel !== exp_px) begin
          if (err_count < 30)
            $display("%0t: pooled pixel mismatch, expected r=%02h g=%02h b=%02h last=%0b,%s",
                     $time, exp_px.out_red, exp_px.out_green, exp_px.out_blue,
                     exp_px.frame_last, " actual below");
          if (err_count < 30)
            $display("%0t:   actual r=%02h g=%02h b=%02h last=%0b", $time,
                     out_pixel.out_red, out_pixel.out_green, out_pixel.out_blue,
                     out_pixel.frame_last);
          err_count++;
        end
      end
    end
  end

  // reset values: 480 x 480, 2 x 2 max; the first windows close early in the second row
  task automatic test_default_config();
    int unsigned i;
    for (i = 0; i < 484; i++) send_pixel(i == 0, pick_sample(), pick_sample(), pick_sample());
  endtask

  task automatic test_directed_extremes();
    set_config(2, 2, 2, MODE_MAX);
    send_pixel(1'b1, 8'hFF, 8'h00, 8'h00);
    send_pixel(1'b0, 8'h00, 8'hFF, 8'h00);
    send_pixel(1'b0, 8'h00, 8'h00, 8'hFF);
    send_pixel(1'b0, 8'h01, 8'h02, 8'h03);
    repeat (4) send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
    set_config(2, 2, 2, MODE_AVG);
    send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
    repeat (3) send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
    // truncation: 255/4 and 3/4
    send_pixel(1'b0, 8'hFF, 8'h01, 8'h03);
    send_pixel(1'b0, 8'h00, 8'h01, 8'h00);
    send_pixel(1'b0, 8'h00, 8'h01, 8'h00);
    send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
    set_config(2, 1, 1, MODE_AVG);
    send_pixel(1'b1, 8'hAA, 8'h55, 8'h0F);
    send_pixel(1'b0, 8'h55, 8'hAA, 8'hF0);
  endtask

  // out-of-range registers saturate; a window wider than the image emits nothing
  task automatic test_register_clamping();
    int unsigned i;
    set_config(11'h7FF, 0, 0, MODE_AVG);
    for (i = 0; i < 40; i++) send_pixel(i == 0, pick_sample(), pick_sample(), pick_sample());
    set_config(0, 13'h1FFF, 15, MODE_MAX);
    for (i = 0; i < 20; i++) send_pixel(i == 0, pick_sample(), pick_sample(), pick_sample());
    set_config(8, 8, 15, MODE_AVG);
    for (i = 0; i < 64; i++) send_pixel(i == 0, pick_sample(), pick_sample(), pick_sample());
  endtask

  // early restart, frames that follow without frame_start, dropped edges
  task automatic test_frame_sequencing();
    int unsigned i;
    set_config(4, 4, 2, MODE_MAX);
    for (i = 0; i < 6; i++) send_pixel(i == 0, pick_sample(), pick_sample(), pick_sample());
    for (i = 0; i < 32; i++) send_pixel(i == 0, pick_sample(), pick_sample(), pick_sample());
    set_config(6, 4, 3, MODE_AVG);
    for (i = 0; i < 48; i++) send_pixel(i == 0, pick_sample(), pick_sample(), pick_sample());
    set_config(7, 5, 2, MODE_AVG);
    for (i = 0; i < 40; i++) send_pixel(i == 0, pick_sample(), pick_sample(), pick_sample());
  endtask

  // receiver holds off while the sender keeps offering; then a mid-frame pause
  task automatic test_backpressure();
    int unsigned i;
    set_config(12, 8, 1, MODE_MAX);
    tx_idling = 1'b0;
    rx_hold_cycles = 200;
    for (i = 0; i < 96; i++) send_pixel(i == 0, pick_sample(), pick_sample(), pick_sample());
    tx_idling = 1'b1;
    set_config(8, 8, 2, MODE_AVG);
    for (i = 0; i < 40; i++) send_pixel(i == 0, pick_sample(), pick_sample(), pick_sample());
    wait_for_drain();
    for (i = 0; i < 24; i++) send_pixel(1'b0, pick_sample(), pick_sample(), pick_sample());
  endtask

  task automatic test_random_streams();
    int unsigned sent, n, frame, i;
    logic [CFG_DATA_BITS-1:0] w_raw, h_raw, k_raw;
    sent = 0;
    while (sent < 150) begin
      if ($urandom_range(0, 9) == 0) begin
        w_raw = CFG_DATA_BITS'($urandom_range(25, 2047));
        h_raw = CFG_DATA_BITS'($urandom_range(0, 3));
      end else begin
        w_raw = CFG_DATA_BITS'($urandom_range(0, 12));
        h_raw = CFG_DATA_BITS'($urandom_range(0, 12));
      end
      k_raw = ($urandom_range(0, 9) < 8) ? CFG_DATA_BITS'($urandom_range(1, 4))
                                         : CFG_DATA_BITS'($urandom_range(0, 15));
      set_config(w_raw, h_raw, k_raw, pool_mode_e'($urandom_range(0, 1)));
      tx_idling = ($urandom_range(0, 3) != 0);
      rx_idling = ($urandom_range(0, 3) != 0);
      frame = clamp_u(w_raw, 1, LINE_DEPTH) * clamp_u(h_raw, 1, ROWS_MAX);
      n = frame * $urandom_range(1, 2) + $urandom_range(0, frame / 2);
      if (n > 60) n = 60;
      // first pixel always restarts; an occasional stray restart mid-frame
      for (i = 0; i < n; i++)
        send_pixel(i == 0 || $urandom_range(0, 199) == 0, pick_sample(), pick_sample(),
                   pick_sample());
      sent += n;
    end
    tx_idling = 1'b1;
    rx_idling = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_default_config();
    test_directed_extremes();
    test_register_clamping();
    test_frame_sequencing();
    test_backpressure();
    test_random_streams();
    wait_for_drain();
    if (err_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/rgbpd_pkg.sv
src/rgbpd_ram.sv
src/rgb_pooling_downsampler_top.sv
test/tb_rgb_pooling_downsampler_top.sv
